/* rtl/pptc_pkg.sv */
// Shared types, constants and helper functions for the payload plaintext classifier.
`default_nettype none

package pptc_pkg;

	// Longest payload that is counted; later bytes are ignored.
	localparam int MAX_PAYLOAD_DEF = 255;

	// Reset value of the minimum text length register.
	localparam logic [7:0] MIN_TEXT_LEN_RST = 8'd8;

	// Length thresholds for the printable confidence tiers.
	localparam logic [7:0] LEN_TIER_HI  = 8'd16;
	localparam logic [7:0] LEN_TIER_MID = 8'd12;

	// Distinct byte values saturate at this count.
	localparam logic [2:0] DISTINCT_MAX = 3'd4;
	localparam logic [2:0] DISTINCT_LOW = 3'd3;

	// Printable range and the accepted control characters.
	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_HI = 8'h7E;
	localparam logic [7:0] CHR_TAB  = 8'h09;
	localparam logic [7:0] CHR_LF   = 8'h0A;
	localparam logic [7:0] CHR_CR   = 8'h0D;

	// Characters that hint at structured text.
	localparam logic [7:0] CHR_OPEN  = 8'h7B;
	localparam logic [7:0] CHR_CLOSE = 8'h7D;
	localparam logic [7:0] CHR_QUOTE = 8'h22;
	localparam logic [7:0] CHR_COLON = 8'h3A;
	localparam logic [7:0] CHR_COMMA = 8'h2C;
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_NINE  = 8'h39;

	// Confidence values.
	localparam logic [6:0] CONF_NONE   = 7'd0;
	localparam logic [6:0] CONF_JSON   = 7'd97;
	localparam logic [6:0] CONF_CSV    = 7'd92;
	localparam logic [6:0] CONF_TEXT_H = 7'd95;
	localparam logic [6:0] CONF_TEXT_M = 7'd90;
	localparam logic [6:0] CONF_TEXT_L = 7'd80;
	localparam logic [6:0] CONF_LOWDIV = 7'd70;

	// Stream widths.
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_TEXT   = 2'd1,
		KIND_STRUCT = 2'd2,
		KIND_LOWDIV = 2'd3
	} kind_t;

	typedef struct packed {
		logic open_brace;
		logic close_brace;
		logic quote_colon;
		logic comma;
		logic digit;
	} char_flags_t;

	// Per-payload summary handed from the accumulator to the verdict logic.
	typedef struct packed {
		logic        all_printable;
		logic [2:0]  distinct;
		char_flags_t flags;
	} summary_t;

	function automatic logic is_printable(input logic [7:0] b);
		is_printable = ((b >= PRINT_LO) && (b <= PRINT_HI)) ||
			(b == CHR_TAB) || (b == CHR_LF) || (b == CHR_CR);
	endfunction

	function automatic char_flags_t classify(input logic [7:0] b);
		char_flags_t f;
		f.open_brace  = (b == CHR_OPEN);
		f.close_brace = (b == CHR_CLOSE);
		f.quote_colon = (b == CHR_QUOTE) || (b == CHR_COLON);
		f.comma       = (b == CHR_COMMA);
		f.digit       = (b >= CHR_ZERO) && (b <= CHR_NINE);
		classify = f;
	endfunction

endpackage

`default_nettype wire

/* rtl/pptc_accum.sv */
// Per-payload accumulator: byte count, distinct value slots, distinct count and character flags.
`default_nettype none

module pptc_accum #(
	parameter int MAX_PAYLOAD = pptc_pkg::MAX_PAYLOAD_DEF,
	parameter int CNT_W       = $clog2(MAX_PAYLOAD + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        data_byte,
	input  wire logic              last_byte,
	input  wire logic              advance,
	output      logic [CNT_W-1:0]  count_next,
	output      pptc_pkg::summary_t summ_next
);

	// The distinct count saturates, so only the values seen before it saturates have to be
	// remembered: one slot fewer than the saturation count.
	localparam int SLOTS  = int'(pptc_pkg::DISTINCT_MAX) - 1;
	localparam int SLOT_W = $clog2(SLOTS);

	logic [7:0]         vals_q [SLOTS];
	logic [CNT_W-1:0]   count_q;
	pptc_pkg::summary_t summ_q;
	logic               in_range;
	logic               seen_hit;
	logic               slot_free;

	assign in_range  = count_q < CNT_W'(MAX_PAYLOAD);
	assign slot_free = summ_q.distinct < 3'(SLOTS);

	// Only the slots below the distinct count hold values of the current payload.
	always_comb begin
		seen_hit = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if ((3'(i) < summ_q.distinct) && (vals_q[i] == data_byte)) begin
				seen_hit = 1'b1;
			end
		end
	end

	always_comb begin
		count_next = count_q;
		summ_next  = summ_q;
		if (in_range) begin
			count_next = count_q + CNT_W'(1);
			if (!pptc_pkg::is_printable(data_byte)) begin
				summ_next.all_printable = 1'b0;
			end
			if (!seen_hit && (summ_q.distinct < pptc_pkg::DISTINCT_MAX)) begin
				summ_next.distinct = summ_q.distinct + 3'd1;
			end
			summ_next.flags = summ_q.flags | pptc_pkg::classify(data_byte);
		end
	end

	// The whole payload state clears when the last byte goes through.
	// The value slots need no clearing, since a zero distinct count hides them all.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				vals_q[i] <= '0;
			end
			count_q               <= '0;
			summ_q.all_printable  <= 1'b1;
			summ_q.distinct       <= '0;
			summ_q.flags          <= '0;
		end else if (advance) begin
			if (last_byte) begin
				count_q              <= '0;
				summ_q.all_printable <= 1'b1;
				summ_q.distinct      <= '0;
				summ_q.flags         <= '0;
			end else begin
				if (in_range && !seen_hit && slot_free) begin
					vals_q[summ_q.distinct[SLOT_W-1:0]] <= data_byte;
				end
				count_q <= count_next;
				summ_q  <= summ_next;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/pptc_verdict.sv */
// Verdict logic: turns the finished payload summary into a signal kind and a confidence.
`default_nettype none

module pptc_verdict #(
	parameter int CNT_W = 8
) (
	input  wire logic [CNT_W-1:0]   byte_count,
	input  wire pptc_pkg::summary_t summ,
	input  wire logic [7:0]         min_text_len,
	output      pptc_pkg::kind_t    signal_kind,
	output      logic [6:0]         confidence
);

	logic [8:0] n;
	logic       long_enough;
	logic       len_mid;
	logic       len_hi;
	logic       json;
	logic       csv;

	assign n           = 9'(byte_count);
	assign long_enough = n >= 9'(min_text_len);
	assign len_mid     = n >= 9'(pptc_pkg::LEN_TIER_MID);
	assign len_hi      = n >= 9'(pptc_pkg::LEN_TIER_HI);
	assign json        = summ.flags.open_brace && summ.flags.close_brace &&
		summ.flags.quote_colon;
	assign csv         = summ.flags.comma && summ.flags.digit && len_mid;

	always_comb begin
		signal_kind = pptc_pkg::KIND_NONE;
		confidence  = pptc_pkg::CONF_NONE;
		if (long_enough) begin
			if (summ.all_printable && json) begin
				signal_kind = pptc_pkg::KIND_STRUCT;
				confidence  = pptc_pkg::CONF_JSON;
			end else if (summ.all_printable && csv) begin
				signal_kind = pptc_pkg::KIND_STRUCT;
				confidence  = pptc_pkg::CONF_CSV;
			end else if (summ.all_printable) begin
				signal_kind = pptc_pkg::KIND_TEXT;
				if (len_hi) begin
					confidence = pptc_pkg::CONF_TEXT_H;
				end else if (len_mid) begin
					confidence = pptc_pkg::CONF_TEXT_M;
				end else begin
					confidence = pptc_pkg::CONF_TEXT_L;
				end
			end else if (len_hi && (summ.distinct <= pptc_pkg::DISTINCT_LOW)) begin
				signal_kind = pptc_pkg::KIND_LOWDIV;
				confidence  = pptc_pkg::CONF_LOWDIV;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/payload_plaintext_classifier.sv */
// Top level of the payload plaintext classifier: input stage, accumulator, verdict, result.
//
//  Channel   Direction  Signals                          Moves
//  s_axis    in         s_tvalid/s_tready/s_tdata/s_tlast one payload byte per transaction
//  m_axis    out        m_tvalid/m_tready/m_tdata        one verdict per payload
//  cfg       in         cfg_valid/cfg_ready/cfg_data     min_text_len register write
//
// One byte is taken per cycle while no last byte waits in the stage register; a byte is
// registered in the stage register and updates the payload state as it leaves the stage,
// where a last byte also loads its verdict into the result register that drives m_tvalid.
// The distinct-value test compares each byte against three stored byte values and feeds
// the payload state straight back into its own registers.
// Reset is asynchronous and active low; it clears the payload state and sets min_text_len to 8.
// Middle bytes never wait on the result side. A last byte waits in the stage register only while
// an earlier verdict is still held and not taken, and new bytes are taken behind it as it leaves.
`default_nettype none

module payload_plaintext_classifier #(
	parameter int MAX_PAYLOAD = pptc_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Input stream; s_tdata[7:0] = data_byte, s_tlast = last_byte.
	input  wire logic                             s_tvalid,
	output      logic                             s_tready,
	input  wire logic [pptc_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  wire logic                             s_tlast,
	// Result stream; m_tdata[1:0] = signal_kind, [8:2] = confidence, [15:9] = zero.
	output      logic                             m_tvalid,
	input  wire logic                             m_tready,
	output      logic [pptc_pkg::OUT_TDATA_W-1:0] m_tdata,
	// Configuration write; cfg_data = min_text_len.
	input  wire logic                             cfg_valid,
	output      logic                             cfg_ready,
	input  wire logic [7:0]                       cfg_data
);

	localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

	// Input stage register.
	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               last_s1;

	// Result register.
	logic               out_valid_q;
	pptc_pkg::kind_t    kind_q;
	logic [6:0]         conf_q;

	logic [7:0]         min_len_q;

	logic               out_free;
	logic               advance;
	logic               in_take;
	logic [CNT_W-1:0]   count_next;
	pptc_pkg::summary_t summ_next;
	pptc_pkg::kind_t    kind_next;
	logic [6:0]         conf_next;

	// A last byte may leave the stage only when the result register is free or being
	// emptied this cycle; every other byte leaves as soon as it is there.
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || advance;
	assign in_take  = s_tvalid && s_tready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= pptc_pkg::MIN_TEXT_LEN_RST;
		end else if (cfg_valid) begin
			min_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= s_tdata[7:0];
			last_s1 <= s_tlast;
		end
	end

	pptc_accum #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.CNT_W       (CNT_W)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (byte_s1),
		.last_byte  (last_s1),
		.advance    (advance),
		.count_next (count_next),
		.summ_next  (summ_next)
	);

	pptc_verdict #(
		.CNT_W (CNT_W)
	) u_verdict (
		.byte_count   (count_next),
		.summ         (summ_next),
		.min_text_len (min_len_q),
		.signal_kind  (kind_next),
		.confidence   (conf_next)
	);

	// The result register loads when a last byte leaves the stage and otherwise drains
	// once the downstream side takes the transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			kind_q <= kind_next;
			conf_q <= conf_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, conf_q, kind_q};

endmodule

`default_nettype wire

/* rtl/pptc_checker.sv */
// Port-level checker for the payload plaintext classifier, bound to the top level.
`default_nettype none

module pptc_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tvalid,
	input wire logic                             s_tready,
	input wire logic [pptc_pkg::IN_TDATA_W-1:0]  s_tdata,
	input wire logic                             s_tlast,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [pptc_pkg::OUT_TDATA_W-1:0] m_tdata,
	input wire logic                             cfg_valid,
	input wire logic                             cfg_ready,
	input wire logic [7:0]                       cfg_data
);

	// A held verdict stays put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("verdict changed or dropped while stalled");

	// A fresh verdict goes valid only after a last byte was taken, with the stage register and
	// the result register between that transaction and the verdict.
	a_out_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
		else $error("verdict without a last byte");

	// No evidence and zero confidence go together, and the padding bits are zero.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[1:0] == pptc_pkg::KIND_NONE) ==
			(m_tdata[8:2] == pptc_pkg::CONF_NONE)) && (m_tdata[15:9] == 7'd0))
		else $error("kind and confidence disagree");

	// Each kind carries only its own confidence values.
	a_kind_conf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
			((m_tdata[1:0] == pptc_pkg::KIND_STRUCT) &&
				((m_tdata[8:2] == pptc_pkg::CONF_JSON) ||
				 (m_tdata[8:2] == pptc_pkg::CONF_CSV))) ||
			((m_tdata[1:0] == pptc_pkg::KIND_TEXT) &&
				((m_tdata[8:2] == pptc_pkg::CONF_TEXT_H) ||
				 (m_tdata[8:2] == pptc_pkg::CONF_TEXT_M) ||
				 (m_tdata[8:2] == pptc_pkg::CONF_TEXT_L))) ||
			((m_tdata[1:0] == pptc_pkg::KIND_LOWDIV) &&
				(m_tdata[8:2] == pptc_pkg::CONF_LOWDIV)) ||
			(m_tdata[1:0] == pptc_pkg::KIND_NONE))
		else $error("confidence does not fit the kind");

endmodule

bind payload_plaintext_classifier pptc_checker u_pptc_checker (.*);

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the payload plaintext classifier with a verdict predictor.
`default_nettype none

module tb;

	localparam int PAY_MAX = pptc_pkg::MAX_PAYLOAD_DEF;

	// One payload byte as it waits to be driven onto the input stream.
	typedef struct {
		logic [7:0] data;
		logic       last;
	} stim_item_t;

	// One predicted verdict, in the field layout of the result stream.
	typedef struct {
		pptc_pkg::kind_t kind;
		logic [6:0]      conf;
	} verdict_t;

	// Content recipes for generated payloads. Most of them are well formed so that the
	// structured and printable verdicts are reached often. The dirty one breaks the
	// printable run with a single control or high byte; the random one draws every byte at random.
	typedef enum int {
		STY_TEXT,
		STY_JSON,
		STY_CSV,
		STY_LOWDIV,
		STY_DIRTY,
		STY_RAND
	} style_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data  = '0;

	// Bytes still to be driven, and verdicts still to arrive.
	stim_item_t byte_q[$];
	verdict_t   verdict_q[$];

	// Mirror of the per-payload state and of the configuration register.
	logic [255:0]          seen_vals;
	logic [7:0]            pay_len;
	logic [2:0]            uniq_cnt;
	logic                  pay_printable;
	pptc_pkg::char_flags_t pay_flags;
	logic [7:0]            min_len = pptc_pkg::MIN_TEXT_LEN_RST;

	// Random idling switches, changed per phase so that some phases run back to back.
	bit tx_idle_on = 1'b0;
	bit rx_idle_on = 1'b0;
	int tx_wait = 0;
	int rx_wait = 0;

	int errors      = 0;
	int bytes_sent  = 0;
	int bytes_made  = 0;
	int verdicts    = 0;
	int cfg_writes  = 0;
	int long_pays   = 0;
	int kind_seen[4];

	payload_plaintext_classifier i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		errors++;
	endtask

	// Printable means the visible ASCII range plus tab, line feed and carriage return.
	function automatic logic printable_byte(input logic [7:0] b);
		return (b >= 8'h20 && b <= 8'h7E) || b == 8'h09 || b == 8'h0A || b == 8'h0D;
	endfunction

	function automatic void start_new_payload();
		seen_vals     = '0;
		pay_len       = '0;
		uniq_cnt      = '0;
		pay_printable = 1'b1;
		pay_flags     = '0;
	endfunction

	// Folds one accepted byte into the mirrored state. A marked byte closes the payload and
	// queues the verdict that the block must give for it.
	function automatic void predict_byte(input logic [7:0] b, input logic last);
		verdict_t v;
		logic     json;
		logic     csv;
		// Bytes past the payload limit leave the state alone, even a marked one.
		if (pay_len < PAY_MAX) begin
			pay_len++;
			if (!printable_byte(b))
				pay_printable = 1'b0;
			if (!seen_vals[b]) begin
				seen_vals[b] = 1'b1;
				if (uniq_cnt < pptc_pkg::DISTINCT_MAX)
					uniq_cnt++;
			end
			if (b == 8'h7B) pay_flags.open_brace = 1'b1;
			if (b == 8'h7D) pay_flags.close_brace = 1'b1;
			if (b == 8'h22 || b == 8'h3A) pay_flags.quote_colon = 1'b1;
			if (b == 8'h2C) pay_flags.comma = 1'b1;
			if (b >= 8'h30 && b <= 8'h39) pay_flags.digit = 1'b1;
		end
		if (last) begin
			v.kind = pptc_pkg::KIND_NONE;
			v.conf = pptc_pkg::CONF_NONE;
			// A payload shorter than the register gives no evidence at all.
			if (pay_len >= min_len) begin
				json = pay_flags.open_brace && pay_flags.close_brace &&
					pay_flags.quote_colon;
				csv  = pay_flags.comma && pay_flags.digit &&
					pay_len >= pptc_pkg::LEN_TIER_MID;
				if (pay_printable && json) begin
					v.kind = pptc_pkg::KIND_STRUCT;
					v.conf = pptc_pkg::CONF_JSON;
				end else if (pay_printable && csv) begin
					v.kind = pptc_pkg::KIND_STRUCT;
					v.conf = pptc_pkg::CONF_CSV;
				end else if (pay_printable) begin
					v.kind = pptc_pkg::KIND_TEXT;
					v.conf = (pay_len >= pptc_pkg::LEN_TIER_HI)  ? pptc_pkg::CONF_TEXT_H :
						(pay_len >= pptc_pkg::LEN_TIER_MID) ? pptc_pkg::CONF_TEXT_M :
						pptc_pkg::CONF_TEXT_L;
				end else if (pay_len >= pptc_pkg::LEN_TIER_HI &&
						uniq_cnt <= pptc_pkg::DISTINCT_LOW) begin
					v.kind = pptc_pkg::KIND_LOWDIV;
					v.conf = pptc_pkg::CONF_LOWDIV;
				end
			end
			verdict_q.push_back(v);
			start_new_payload();
		end
	endfunction

	// Input driver. A byte stays on the bus until it is taken; after each transaction the
	// next byte may be held back at random when idling is on.
	always @(posedge clk or negedge arst_n) begin
		stim_item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
			tx_wait = 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				predict_byte(s_tdata, s_tlast);
				bytes_sent++;
				tx_wait = tx_idle_on ? $urandom_range(0, 3) : 0;
			end
			if (tx_wait > 0) begin
				tx_wait--;
				s_tvalid <= 1'b0;
			end else if (byte_q.size() > 0) begin
				it = byte_q.pop_front();
				s_tdata  <= it.data;
				s_tlast  <= it.last;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result monitor. Every verdict transaction is checked against the oldest prediction,
	// then ready may drop at random when idling is on.
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				verdicts++;
				kind_seen[m_tdata[1:0]]++;
				if (verdict_q.size() == 0) begin
					report_mismatch($sformatf("verdict %h with no payload outstanding",
						m_tdata));
				end else begin
					want = verdict_q.pop_front();
					if (m_tdata[1:0] !== want.kind)
						report_mismatch($sformatf("signal_kind %0d, expected %0d",
							m_tdata[1:0], want.kind));
					if (m_tdata[8:2] !== want.conf)
						report_mismatch($sformatf("confidence %0d, expected %0d",
							m_tdata[8:2], want.conf));
					if (m_tdata[15:9] !== 7'd0)
						report_mismatch($sformatf("padding bits %h not zero",
							m_tdata[15:9]));
				end
				rx_wait = rx_idle_on ? $urandom_range(0, 3) : 0;
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			m_tready <= (rx_wait == 0);
		end
	end

	function automatic logic [7:0] text_char();
		case ($urandom_range(0, 15))
			0:       return 8'h09;
			1:       return 8'h0A;
			2:       return 8'h0D;
			default: return 8'($urandom_range(8'h20, 8'h7E));
		endcase
	endfunction

	function automatic logic [7:0] noise_char();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		while (printable_byte(b))
			b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic last);
		stim_item_t it;
		it.data = b;
		it.last = last;
		byte_q.push_back(it);
		bytes_made++;
	endtask

	// Builds one payload of the given length and recipe and queues it, marked on its last byte.
	task automatic queue_payload(input int len, input style_t sty);
		logic [7:0] pay[];
		logic [7:0] pal[4];
		int         npal;
		pay  = new[len];
		npal = $urandom_range(1, 4);
		foreach (pal[j])
			pal[j] = 8'($urandom_range(0, 255));
		for (int i = 0; i < len; i++) begin
			case (sty)
				STY_RAND:   pay[i] = 8'($urandom_range(0, 255));
				STY_LOWDIV: pay[i] = pal[$urandom_range(0, npal - 1)];
				STY_CSV: begin
					case ($urandom_range(0, 3))
						0:       pay[i] = 8'h2C;
						1:       pay[i] = text_char();
						default: pay[i] = 8'(8'h30 + $urandom_range(0, 9));
					endcase
				end
				default:    pay[i] = text_char();
			endcase
		end
		// Each of the three JSON markers is left out now and then, which breaks the JSON case.
		if (sty == STY_JSON) begin
			if ($urandom_range(0, 4) != 0) pay[$urandom_range(0, len - 1)] = 8'h7B;
			if ($urandom_range(0, 4) != 0) pay[$urandom_range(0, len - 1)] = 8'h7D;
			if ($urandom_range(0, 4) != 0)
				pay[$urandom_range(0, len - 1)] = $urandom_range(0, 1) ? 8'h22 : 8'h3A;
		end
		// A single bad byte spoils otherwise clean text, or a clean-looking structured payload.
		if (sty == STY_DIRTY ||
				((sty == STY_JSON || sty == STY_CSV) && $urandom_range(0, 7) == 0))
			pay[$urandom_range(0, len - 1)] = noise_char();
		// Whatever lies past the limit is random, so that ignored bytes carry every kind of value.
		for (int i = PAY_MAX; i < len; i++)
			pay[i] = 8'($urandom_range(0, 255));
		if (len > PAY_MAX)
			long_pays++;
		for (int i = 0; i < len; i++)
			push_byte(pay[i], i == len - 1);
	endtask

	// Waits until no byte is queued or on the bus and every verdict is in, then lets the
	// block's two-stage pipeline settle. No new bytes are queued while it waits.
	task automatic wait_drained();
		while (byte_q.size() != 0 || s_tvalid || verdict_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes the minimum length register while the block is idle and updates the mirror.
	task automatic write_min_len(input logic [7:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		min_len = v;
		cfg_writes++;
	endtask

	// Queues short random payloads until the phase holds about the given number of bytes.
	task automatic random_phase(input logic [7:0] cfg_val, input int phase, input int quota);
		int start;
		int len;
		write_min_len(cfg_val);
		tx_idle_on = (phase % 3 != 0);
		rx_idle_on = (phase % 4 != 1);
		start = bytes_made;
		while (bytes_made - start < quota) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 48) : $urandom_range(1, 24);
			queue_payload(len, style_t'($urandom_range(0, 5)));
		end
	endtask

	initial begin
		start_new_payload();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the reset value of the register: single bytes at both ends of
		// the byte range are too short for any verdict.
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);

		// Register at one: a tiny JSON object, a short digit-comma pair that is
		// too short for the comma-separated case, the printable edges, and a lone control byte.
		write_min_len(8'd1);
		push_byte(8'h7B, 1'b0);
		push_byte(8'h22, 1'b0);
		push_byte(8'h3A, 1'b0);
		push_byte(8'h7D, 1'b1);
		push_byte(8'h39, 1'b0);
		push_byte(8'h2C, 1'b1);
		push_byte(8'h09, 1'b0);
		push_byte(8'h0A, 1'b0);
		push_byte(8'h0D, 1'b0);
		push_byte(8'h20, 1'b0);
		push_byte(8'h7E, 1'b1);
		push_byte(8'h1F, 1'b1);

		// Register at zero: every payload is long enough, so any printable byte counts as text.
		write_min_len(8'd0);
		push_byte(8'h7F, 1'b1);
		push_byte(8'h30, 1'b1);
		push_byte(8'h2F, 1'b0);
		push_byte(8'h3A, 1'b0);
		push_byte(8'h39, 1'b0);
		push_byte(8'h7B, 1'b0);
		push_byte(8'h7D, 1'b0);
		push_byte(8'h0B, 1'b1);

		// Largest register value: only full-length payloads can give evidence. The bytes past
		// the limit, the marked one included, must not change the verdict.
		write_min_len(8'd255);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		queue_payload(258, STY_LOWDIV);
		queue_payload(6, STY_JSON);

		// Random phases across the tier thresholds and the register extremes.
		random_phase(8'd12, 0, 45);
		random_phase(8'd16, 1, 45);
		random_phase(8'd0, 2, 45);
		random_phase(8'd20, 3, 45);
		random_phase(8'd1, 4, 45);
		random_phase(pptc_pkg::MIN_TEXT_LEN_RST, 5, 45);
		random_phase(8'($urandom_range(2, 30)), 6, 45);

		wait_drained();
		repeat (10) @(posedge clk);

		$display("Run covered %0d bytes in %0d payloads (%0d past the length limit),",
			bytes_sent, verdicts, long_pays);
		$display("%0d register writes; verdicts: none %0d, text %0d, structured %0d, low div %0d.",
			cfg_writes, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches found.", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#3000000;
		$display("Timeout with %0d verdicts outstanding.", verdict_q.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
rtl/pptc_pkg.sv
rtl/pptc_accum.sv
rtl/pptc_verdict.sv
rtl/payload_plaintext_classifier.sv
rtl/pptc_checker.sv
verif/tb.sv
